// File: sv/assert_macros.svh
// Assertion macros used by the top level of the height field shaper.
// Defining ASSERT_OFF turns every check into an empty statement.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define HGS_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define HGS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define HGS_ASSERT(lbl, clk, rst, prop, msg)
`define HGS_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

// File: sv/hgs_pkg.sv
// Shared types, codes and constant tables of the height field shaper.
// No dependencies; imported by the controller, datapath and top level.
`timescale 1ns / 1ps
package hgs_pkg;

   localparam int DEF_MAX_WIDTH  = 128;
   localparam int DEF_MAX_HEIGHT = 128;
   localparam int DEF_MAX_RADIUS = 6;

   localparam logic [2:0] REG_SHAPE        = 3'd0;
   localparam logic [2:0] REG_LOCAL_EFFECT = 3'd1;
   localparam logic [2:0] REG_LOCAL_AREA   = 3'd2;
   localparam logic [2:0] REG_KEEP_DETAIL  = 3'd3;
   localparam logic [2:0] REG_RADIUS       = 3'd4;
   localparam logic [2:0] REG_WIDTH        = 3'd5;
   localparam logic [2:0] REG_HEIGHT       = 3'd6;

   localparam logic OPC_STORE   = 1'b0;
   localparam logic OPC_COMPUTE = 1'b1;

   typedef enum logic [4:0] {
      OP_NOP,
      OP_CENTER,
      OP_LATCH_U,
      OP_EXPG_INIT,
      OP_EXPS_INIT,
      OP_EXP_MUL,
      OP_EXP_ACC,
      OP_EXPG_FIN,
      OP_EXPS_FIN,
      OP_LOG_INIT,
      OP_LOG_MUL,
      OP_LOG_ACC,
      OP_PROD_MUL,
      OP_WT_MUL,
      OP_WT_ACC,
      OP_RES_MUL,
      OP_RES_ACC,
      OP_WIN_INIT,
      OP_WIN_STEP,
      OP_DIV_INIT,
      OP_DIV_STEP,
      OP_FINAL
   } hgs_op_type;

   typedef struct packed {
      hgs_op_type op;
   } hgs_cmd_type;

   typedef struct packed {
      logic k_last16;
      logic k_last24;
      logic win_last;
      logic u_zero;
      logic keep_detail;
   } hgs_status_type;

   typedef logic [31:0] fac_tab_type [16];

   function automatic logic [63:0] isqrt64(input logic [63:0] v);
      logic [63:0] res;
      logic [63:0] bit_v;
      logic [63:0] vv;
      res   = '0;
      bit_v = 64'h4000_0000_0000_0000;
      vv    = v;
      for (int i = 0; i < 32; i++) begin
         if (vv >= res + bit_v) begin
            vv  = vv - (res + bit_v);
            res = (res >> 1) + bit_v;
         end else begin
            res = res >> 1;
         end
         bit_v = bit_v >> 2;
      end
      return res;
   endfunction

   // 2^(2^-k) in Q2.30 for k = 1..16
   function automatic fac_tab_type make_fac();
      fac_tab_type tab;
      logic [63:0] fac;
      fac = 64'h8000_0000;
      for (int k = 0; k < 16; k++) begin
         fac    = isqrt64(fac << 30);
         tab[k] = fac[31:0];
      end
      return tab;
   endfunction

   localparam fac_tab_type FAC_TABLE = make_fac();

endpackage

// File: sv/heightfield_gamma_shaper.sv
// Height field gamma shaper, top level. A compute runs the 16-step exp2/log2 loops
// on the shared multiplier and, with detail, one field store read per cycle over
// the (2r+1)^2 window (r = radius) and a 24-step divider; the log2 and second exp2
// loops are skipped for a sample at minus one.
// Synchronous active-high reset clears control and loads the CSR defaults; the store is not cleared.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module heightfield_gamma_shaper import hgs_pkg::*; #(
   parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
   parameter int MAX_RADIUS = DEF_MAX_RADIUS
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_opcode,
   input  logic [6:0]         req_column,
   input  logic [6:0]         req_row,
   input  logic signed [15:0] req_sample,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [6:0]         rsp_out_column,
   output logic [6:0]         rsp_out_row,
   output logic signed [15:0] rsp_new_height,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [2:0]         csr_index,
   input  logic [15:0]        csr_data
);

   hgs_cmd_type    cmd;
   hgs_status_type status;
   logic           req_fire;

   assign csr_ready = 1'b1;
   assign req_fire  = req_valid && req_ready;

   hgs_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_opcode (req_opcode),
      .req_ready  (req_ready),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .status     (status),
      .cmd        (cmd)
   );

   hgs_dp #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT),
      .MAX_RADIUS (MAX_RADIUS)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .req_fire       (req_fire),
      .req_opcode     (req_opcode),
      .req_column     (req_column),
      .req_row        (req_row),
      .req_sample     (req_sample),
      .csr_fire       (csr_valid && csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data),
      .rsp_out_column (rsp_out_column),
      .rsp_out_row    (rsp_out_row),
      .rsp_new_height (rsp_new_height)
   );

   `HGS_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid, "rsp dropped")
   `HGS_ASSERT(a_busy_after_compute, clock, reset, req_fire && req_opcode == OPC_COMPUTE |=> !req_ready, "accepted during compute")
   `HGS_ASSERT_ALWAYS(a_reset_clears, clock, reset |=> !rsp_valid, "rsp_valid after reset")

endmodule

// File: sv/hgs_ctrl.sv
// Sequencer of the height field shaper: steps the datapath through one transaction.
// Depends on hgs_pkg for the command and status types.
`timescale 1ns / 1ps
module hgs_ctrl import hgs_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   input  logic           req_opcode,
   output logic           req_ready,
   output logic           rsp_valid,
   input  logic           rsp_ready,
   input  hgs_status_type status,
   output hgs_cmd_type    cmd
);

   typedef enum logic [4:0] {
      ST_IDLE, ST_CENTER, ST_LATCH,
      ST_G_INIT, ST_G_MUL, ST_G_ACC, ST_G_FIN,
      ST_L_INIT, ST_L_MUL, ST_L_ACC, ST_P_MUL,
      ST_S_INIT, ST_S_MUL, ST_S_ACC, ST_S_FIN,
      ST_W_MUL, ST_W_ACC, ST_R_MUL, ST_R_ACC,
      ST_N_INIT, ST_N_STEP, ST_N_DRAIN, ST_D_INIT, ST_D_STEP, ST_DONE
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_ready ? 1'b0 : rsp_valid_ff;
      cmd.op       = OP_NOP;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid && req_opcode == OPC_COMPUTE) state_in = ST_CENTER;
         end
         ST_CENTER: begin
            cmd.op = OP_CENTER; state_in = ST_LATCH;
         end
         ST_LATCH: begin
            cmd.op = OP_LATCH_U; state_in = ST_G_INIT;
         end
         ST_G_INIT: begin
            cmd.op = OP_EXPG_INIT; state_in = ST_G_MUL;
         end
         ST_G_MUL: begin
            cmd.op = OP_EXP_MUL; state_in = ST_G_ACC;
         end
         ST_G_ACC: begin
            cmd.op = OP_EXP_ACC; state_in = status.k_last16 ? ST_G_FIN : ST_G_MUL;
         end
         ST_G_FIN: begin
            cmd.op = OP_EXPG_FIN; state_in = status.u_zero ? ST_W_MUL : ST_L_INIT;
         end
         ST_L_INIT: begin
            cmd.op = OP_LOG_INIT; state_in = ST_L_MUL;
         end
         ST_L_MUL: begin
            cmd.op = OP_LOG_MUL; state_in = ST_L_ACC;
         end
         ST_L_ACC: begin
            cmd.op = OP_LOG_ACC; state_in = status.k_last16 ? ST_P_MUL : ST_L_MUL;
         end
         ST_P_MUL: begin
            cmd.op = OP_PROD_MUL; state_in = ST_S_INIT;
         end
         ST_S_INIT: begin
            cmd.op = OP_EXPS_INIT; state_in = ST_S_MUL;
         end
         ST_S_MUL: begin
            cmd.op = OP_EXP_MUL; state_in = ST_S_ACC;
         end
         ST_S_ACC: begin
            cmd.op = OP_EXP_ACC; state_in = status.k_last16 ? ST_S_FIN : ST_S_MUL;
         end
         ST_S_FIN: begin
            cmd.op = OP_EXPS_FIN; state_in = ST_W_MUL;
         end
         ST_W_MUL: begin
            cmd.op = OP_WT_MUL; state_in = ST_W_ACC;
         end
         ST_W_ACC: begin
            cmd.op = OP_WT_ACC; state_in = ST_R_MUL;
         end
         ST_R_MUL: begin
            cmd.op = OP_RES_MUL; state_in = ST_R_ACC;
         end
         ST_R_ACC: begin
            cmd.op = OP_RES_ACC; state_in = status.keep_detail ? ST_N_INIT : ST_DONE;
         end
         ST_N_INIT: begin
            cmd.op = OP_WIN_INIT; state_in = ST_N_STEP;
         end
         ST_N_STEP: begin
            cmd.op = OP_WIN_STEP; state_in = status.win_last ? ST_N_DRAIN : ST_N_STEP;
         end
         ST_N_DRAIN: begin
            state_in = ST_D_INIT;
         end
         ST_D_INIT: begin
            cmd.op = OP_DIV_INIT; state_in = ST_D_STEP;
         end
         ST_D_STEP: begin
            cmd.op = OP_DIV_STEP; state_in = status.k_last24 ? ST_DONE : ST_D_STEP;
         end
         ST_DONE: begin
            if (out_free) begin
               cmd.op = OP_FINAL; rsp_valid_in = 1'b1; state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// File: sv/hgs_dp.sv
// Datapath of the height field shaper: field store, CSRs, shared multiplier,
// log2/exp2 iteration, box mean and divider. Depends on hgs_pkg.
`timescale 1ns / 1ps
module hgs_dp import hgs_pkg::*; #(
   parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
   parameter int MAX_RADIUS = DEF_MAX_RADIUS
) (
   input  logic               clock,
   input  logic               reset,
   input  hgs_cmd_type        cmd,
   output hgs_status_type     status,
   input  logic               req_fire,
   input  logic               req_opcode,
   input  logic [6:0]         req_column,
   input  logic [6:0]         req_row,
   input  logic signed [15:0] req_sample,
   input  logic               csr_fire,
   input  logic [2:0]         csr_index,
   input  logic [15:0]        csr_data,
   output logic [6:0]         rsp_out_column,
   output logic [6:0]         rsp_out_row,
   output logic signed [15:0] rsp_new_height
);

   localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic [15:0] mem [DEPTH];
   logic [15:0] rdata_ff;
   logic        rv_ff;
   logic [AW-1:0] wr_addr, rd_addr;
   logic        wr_en;

   logic [15:0] shape_ff, effect_ff, area_ff;
   logic        keep_ff;
   logic [2:0]  radius_ff;
   logic [7:0]  width_ff, height_ff;

   logic [6:0]  col_ff, row_ff;
   logic [10:0] cx_ff, cy_ff;
   logic [15:0] u_ff;
   logic [19:0] gamma_ff;
   logic [30:0] m_ff;
   logic [15:0] frac_ff;
   logic signed [8:0] n_ff;
   logic [4:0]  k_ff;
   logic [30:0] x_ff;
   logic [15:0] lf_ff;
   logic [3:0]  lead_ff;
   logic [16:0] shaped_ff, weight_ff, res_ff;
   logic [23:0] sum_ff, quo_ff;
   logic [8:0]  rem_ff;
   logic [7:0]  cnt_ff;
   logic signed [3:0] dx_ff, dy_ff;
   logic [63:0] p_ff;
   logic [31:0] mul_a, mul_b;

   logic [10:0] w_c, h_c, wm1, hm1;
   logic [2:0]  rad_c;
   logic signed [3:0] rad_s;
   logic [10:0] cx_new, cy_new;
   logic signed [11:0] wc, wr;
   logic [10:0] rc, rr;
   logic [3:0]  lead;
   logic [46:0] xw;
   logic [23:0] t_g, t_s;
   logic signed [23:0] f_g, f_s;
   logic signed [8:0] nc;
   logic [2:0]  lsh;
   logic [7:0]  ramt;
   logic [37:0] ev;
   logic [20:0] lval;
   logic [16:0] area2, eff_c, du, w1, oma, diff, q;
   logic [17:0] dist_x2;
   logic        up;
   logic [31:0] sq;
   logic [9:0]  rem_sh;
   logic [3:0]  twor1;
   logic signed [18:0] rs;
   logic [16:0] rfin;
   logic [15:0] hout;

   // configuration clamps
   always_comb begin
      if (width_ff == 8'd0) w_c = 11'd1;
      else if ({3'b0, width_ff} > 11'(MAX_WIDTH)) w_c = 11'(MAX_WIDTH);
      else w_c = {3'b0, width_ff};
      if (height_ff == 8'd0) h_c = 11'd1;
      else if ({3'b0, height_ff} > 11'(MAX_HEIGHT)) h_c = 11'(MAX_HEIGHT);
      else h_c = {3'b0, height_ff};
      if (radius_ff == 3'd0) rad_c = 3'd1;
      else if (radius_ff > 3'(MAX_RADIUS)) rad_c = 3'(MAX_RADIUS);
      else rad_c = radius_ff;
      wm1    = w_c - 11'd1;
      hm1    = h_c - 11'd1;
      rad_s  = $signed({1'b0, rad_c});
      cx_new = ({4'b0, req_column} > wm1) ? wm1 : {4'b0, req_column};
      cy_new = ({4'b0, req_row} > hm1) ? hm1 : {4'b0, req_row};
   end

   // window coordinates, clamped into the area in use
   always_comb begin
      wc = $signed({1'b0, cx_ff}) + {{8{dx_ff[3]}}, dx_ff};
      wr = $signed({1'b0, cy_ff}) + {{8{dy_ff[3]}}, dy_ff};
      if (wc < 12'sd0) rc = '0;
      else if (wc > $signed({1'b0, wm1})) rc = wm1;
      else rc = wc[10:0];
      if (wr < 12'sd0) rr = '0;
      else if (wr > $signed({1'b0, hm1})) rr = hm1;
      else rr = wr[10:0];
      if (cmd.op != OP_WIN_STEP) begin
         rc = cx_ff;
         rr = cy_ff;
      end
      rd_addr = AW'(32'(rr) * 32'(MAX_WIDTH) + 32'(rc));
      wr_addr = AW'(32'(req_row) * 32'(MAX_WIDTH) + 32'(req_column));
      wr_en   = req_fire && req_opcode == OPC_STORE &&
                {4'b0, req_column} < 11'(MAX_WIDTH) && {4'b0, req_row} < 11'(MAX_HEIGHT);
   end

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= req_sample;
      rdata_ff <= mem[rd_addr];
   end

   // arithmetic helpers
   always_comb begin
      lead = '0;
      for (int i = 0; i < 16; i++) begin
         if (u_ff[i]) lead = 4'(i);
      end
      xw   = {31'b0, u_ff} << (5'd30 - {1'b0, lead});
      f_g  = -($signed({{8{shape_ff[15]}}, shape_ff}) <<< 2);
      f_s  = -$signed(p_ff[39:16]);
      t_g  = f_g + 24'sh80_0000;
      t_s  = f_s + 24'sh80_0000;
      nc   = (n_ff > 9'sd20) ? 9'sd20 : n_ff;
      lsh  = 3'(nc - 9'sd14);
      ramt = 8'(9'sd14 - nc);
      if (nc >= 9'sd14) ev = 38'(m_ff) << lsh;
      else if (ramt >= 8'd63) ev = '0;
      else ev = 38'(m_ff) >> ramt;
      lval  = {5'(5'd16 - {1'b0, lead_ff}), 16'b0} - {5'b0, lf_ff};
      area2 = ((area_ff > 16'd32768) ? 17'd32768 : {1'b0, area_ff}) << 1;
      eff_c = (effect_ff > 16'd32768) ? 17'd32768 : {1'b0, effect_ff};
      du    = ({1'b0, u_ff} > area2) ? {1'b0, u_ff} - area2 : area2 - {1'b0, u_ff};
      dist_x2 = {du, 1'b0};
      w1    = (dist_x2 >= 18'd65536) ? 17'd0 : 17'(18'd65536 - dist_x2);
      oma   = 17'd65536 - w1;
      up    = shaped_ff >= {1'b0, u_ff};
      diff  = up ? shaped_ff - {1'b0, u_ff} : {1'b0, u_ff} - shaped_ff;
      q     = p_ff[32:16];
      sq    = p_ff[61:30];
      rem_sh = {rem_ff, quo_ff[23]};
      twor1  = {rad_c, 1'b1};
      rs = $signed({2'b0, res_ff}) + $signed({3'b0, u_ff}) - $signed({3'b0, quo_ff[15:0]});
      if (!keep_ff) rfin = res_ff;
      else if (rs < 19'sd0) rfin = '0;
      else if (rs > 19'sd65536) rfin = 17'd65536;
      else rfin = rs[16:0];
      hout = rfin[16] ? 16'h7FFF : (rfin[15:0] ^ 16'h8000);
   end

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (cmd.op)
         OP_EXP_MUL: begin
            mul_a = 32'(m_ff); mul_b = FAC_TABLE[k_ff[3:0]];
         end
         OP_LOG_MUL: begin
            mul_a = 32'(x_ff); mul_b = 32'(x_ff);
         end
         OP_PROD_MUL: begin
            mul_a = 32'(gamma_ff); mul_b = 32'(lval);
         end
         OP_WT_MUL: begin
            mul_a = 32'(oma); mul_b = 32'(eff_c);
         end
         OP_RES_MUL: begin
            mul_a = 32'(diff); mul_b = 32'(weight_ff);
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      p_ff <= mul_a * mul_b;
      if (rv_ff) sum_ff <= sum_ff + {8'b0, rdata_ff ^ 16'h8000};
      if (req_fire && req_opcode == OPC_COMPUTE) begin
         col_ff <= req_column;
         row_ff <= req_row;
         cx_ff  <= cx_new;
         cy_ff  <= cy_new;
      end
      case (cmd.op)
         OP_LATCH_U: begin
            u_ff      <= rdata_ff ^ 16'h8000;
            shaped_ff <= '0;
         end
         OP_EXPG_INIT: begin
            m_ff <= 31'h4000_0000; frac_ff <= t_g[15:0];
            n_ff <= $signed({1'b0, t_g[23:16]}) - 9'sd128; k_ff <= '0;
         end
         OP_EXPS_INIT: begin
            m_ff <= 31'h4000_0000; frac_ff <= t_s[15:0];
            n_ff <= $signed({1'b0, t_s[23:16]}) - 9'sd128; k_ff <= '0;
         end
         OP_EXP_ACC: begin
            if (frac_ff[15]) m_ff <= p_ff[60:30];
            frac_ff <= {frac_ff[14:0], 1'b0};
            k_ff    <= k_ff + 5'd1;
         end
         OP_EXPG_FIN: gamma_ff  <= ev[19:0];
         OP_EXPS_FIN: shaped_ff <= ev[16:0];
         OP_LOG_INIT: begin
            x_ff <= xw[30:0]; lf_ff <= '0; lead_ff <= lead; k_ff <= '0;
         end
         OP_LOG_ACC: begin
            if (sq[31]) begin
               x_ff  <= sq[31:1];
               lf_ff <= {lf_ff[14:0], 1'b1};
            end else begin
               x_ff  <= sq[30:0];
               lf_ff <= {lf_ff[14:0], 1'b0};
            end
            k_ff <= k_ff + 5'd1;
         end
         OP_WT_ACC: weight_ff <= 17'd65536 - p_ff[31:15];
         OP_RES_ACC: res_ff <= up ? {1'b0, u_ff} + q : {1'b0, u_ff} - q;
         OP_WIN_INIT: begin
            dx_ff <= -rad_s; dy_ff <= -rad_s; sum_ff <= '0;
         end
         OP_WIN_STEP: begin
            if (dx_ff == rad_s) begin
               dx_ff <= -rad_s;
               dy_ff <= dy_ff + 4'sd1;
            end else begin
               dx_ff <= dx_ff + 4'sd1;
            end
         end
         OP_DIV_INIT: begin
            quo_ff <= sum_ff; rem_ff <= '0; k_ff <= '0;
            cnt_ff <= 8'({4'b0, twor1} * {4'b0, twor1});
         end
         OP_DIV_STEP: begin
            if (rem_sh >= {2'b0, cnt_ff}) begin
               rem_ff <= 9'(rem_sh - {2'b0, cnt_ff});
               quo_ff <= {quo_ff[22:0], 1'b1};
            end else begin
               rem_ff <= rem_sh[8:0];
               quo_ff <= {quo_ff[22:0], 1'b0};
            end
            k_ff <= k_ff + 5'd1;
         end
         OP_FINAL: begin
            rsp_out_column <= col_ff;
            rsp_out_row    <= row_ff;
            rsp_new_height <= hout;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rv_ff     <= 1'b0;
         shape_ff  <= 16'd0;
         effect_ff <= 16'd0;
         area_ff   <= 16'd16384;
         keep_ff   <= 1'b1;
         radius_ff <= 3'd2;
         width_ff  <= 8'd128;
         height_ff <= 8'd128;
      end else begin
         rv_ff <= (cmd.op == OP_WIN_STEP);
         if (csr_fire) begin
            case (csr_index)
               REG_SHAPE:        shape_ff  <= csr_data;
               REG_LOCAL_EFFECT: effect_ff <= csr_data;
               REG_LOCAL_AREA:   area_ff   <= csr_data;
               REG_KEEP_DETAIL:  keep_ff   <= csr_data[0];
               REG_RADIUS:       radius_ff <= csr_data[2:0];
               REG_WIDTH:        width_ff  <= csr_data[7:0];
               REG_HEIGHT:       height_ff <= csr_data[7:0];
               default: ;
            endcase
         end
      end
   end

   assign status.k_last16    = (k_ff == 5'd15);
   assign status.k_last24    = (k_ff == 5'd23);
   assign status.win_last    = (dx_ff == rad_s) && (dy_ff == rad_s);
   assign status.u_zero      = (u_ff == 16'd0);
   assign status.keep_detail = keep_ff;

endmodule
